FILE: hw/rtl/isc_pkg.sv
// Shared types and constants for the integer set table.
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_QUERY  = 2'd3
    } isc_cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } isc_state_t;

    typedef struct packed {
        isc_cmd_t           cmd;
        logic signed [31:0] value;
    } isc_in_t;

    typedef struct packed {
        logic       present;
        logic [4:0] position;
        logic [4:0] element_total;
        logic       full_refused;
    } isc_out_t;

    // Strobes from the controller to every cell of the chain
    typedef struct packed {
        logic lookup;
        logic ins_shift;
        logic del_shift;
    } isc_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/isc_cell.sv
// One storage cell of the set chain: holds a value, compares, shifts.
`timescale 1ns / 1ps
`default_nettype none

module isc_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  wire logic               aclk,
    input  wire isc_pkg::isc_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic [CNT_W-1:0]   del_place,
    input  wire logic signed [31:0] probe,
    input  wire logic signed [31:0] left_value,
    input  wire logic signed [31:0] right_value,
    output logic signed [31:0]      cell_value,
    output logic                    match
);
    import isc_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               match_reg;
    logic               occupied;
    logic               behind_gap;

    assign occupied   = count > CNT_W'(CELL_IDX);
    // cells at or after the deleted place pull from the older neighbor
    assign behind_gap = CNT_W'(CELL_IDX + 1) >= del_place;

    always_comb begin
        value_next = value_reg;
        if (ctrl.ins_shift) begin
            value_next = left_value;
        end else if (ctrl.del_shift && behind_gap) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (ctrl.lookup) begin
            match_reg <= occupied && (value_reg == probe);
        end
    end

    assign cell_value = value_reg;
    assign match      = match_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/integer_set_table.sv
// Top level of the integer set table: controller around a chain of cells.
//
// Keeps a set of distinct 32-bit integers, newest first, in CAPACITY cells.
// Input channel s_valid/s_ready/s_item carries a command (insert, delete,
// membership test, position query) and a value. Result channel
// m_valid/m_ready/m_item returns one item per command: presence before the
// command, one-based position (0 when absent), element count afterwards and
// a flag for an insert dropped because the store was full.
// Each item is handled in a compare step and a shift step: in the accept
// cycle every cell compares its value against the probe and registers a
// match bit; in the LOOKUP state, once the output register is free, the
// matches are reduced to a position, the chain shifts for insert or delete
// and the result is written to the output register. A new item is accepted only after the last is applied.
// The output register lets a new item be accepted while a result waits;
// the shift step holds until that register is free, so a stalled receiver
// stalls the input after one further item.
// Reset (aresetn low, synchronous) empties the set and drops any result.
`timescale 1ns / 1ps
`default_nettype none

module integer_set_table #(
    parameter int CAPACITY = isc_pkg::DEFAULT_CAPACITY
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire isc_pkg::isc_in_t s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output isc_pkg::isc_out_t     m_item
);
    import isc_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    isc_state_t         state_reg;
    isc_state_t         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    isc_cmd_t           cmd_reg;
    logic signed [31:0] probe_reg;
    logic               m_valid_reg;
    isc_out_t           m_item_reg;

    isc_ctrl_t          ctrl;
    logic               out_free;
    logic               apply;
    logic [CAPACITY-1:0] match_vec;
    logic signed [31:0] cell_vals [CAPACITY];
    logic [CNT_W-1:0]   place;
    logic               found;
    logic               do_insert;
    logic               do_delete;
    logic               refused;
    isc_out_t           result;

    assign out_free = !m_valid_reg || m_ready;
    assign apply    = (state_reg == ST_LOOKUP) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_ready        = 1'b0;
        ctrl.lookup    = 1'b0;
        ctrl.ins_shift = 1'b0;
        ctrl.del_shift = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctrl.lookup = s_valid;
            end
            ST_LOOKUP: begin
                ctrl.ins_shift = out_free && do_insert;
                ctrl.del_shift = out_free && do_delete;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // values are distinct, so at most one match: OR the place codes together
    always_comb begin
        place = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            place = place | (match_vec[i] ? CNT_W'(i + 1) : '0);
        end
    end

    assign found     = |match_vec;
    assign do_insert = (cmd_reg == CMD_INSERT) && !found && (count_reg < CNT_W'(CAPACITY));
    assign refused   = (cmd_reg == CMD_INSERT) && !found && (count_reg >= CNT_W'(CAPACITY));
    assign do_delete = (cmd_reg == CMD_DELETE) && found;

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_delete) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        result.present       = found;
        result.position      = 5'(place);
        result.element_total = 5'(count_next);
        result.full_refused  = refused;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] left_v;
            logic signed [31:0] right_v;
            if (g == 0) begin : g_head
                assign left_v = probe_reg;
            end else begin : g_mid
                assign left_v = cell_vals[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign right_v = cell_vals[g];
            end else begin : g_body
                assign right_v = cell_vals[g+1];
            end
            isc_cell #(
                .CELL_IDX (g),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .del_place   (place),
                .probe       (s_item.value),
                .left_value  (left_v),
                .right_value (right_v),
                .cell_value  (cell_vals[g]),
                .match       (match_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lookup) begin
            cmd_reg   <= s_item.cmd;
            probe_reg <= s_item.value;
        end
        if (apply) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOKUP |-> $onehot0(match_vec))
        else $error("value stored in more than one cell");

    a_refuse_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.full_refused |-> !m_item.present)
        else $error("refused insert reported as present");

    a_delete_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.del_shift |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not lower the count");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOKUP && !out_free |=> state_reg == ST_LOOKUP)
        else $error("lookup dropped while output stalled");
`endif

endmodule

`default_nettype wire
